// ===== rtl/ccpd_pkg.sv =====
// Package for the character cell pixel decoder.
// Holds action codes, register indexes, mode codes and the config struct.
// No dependencies.
package ccpd_pkg;

    typedef enum logic [1:0] {
        ACT_DECODE    = 2'd0,
        ACT_PAL_WRITE = 2'd1,
        ACT_BIAS      = 2'd2,
        ACT_NONE      = 2'd3
    } action_t;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_DEPTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_MODE    = 1'd1;

    localparam logic [1:0] DEPTH_2      = 2'd0;
    localparam logic [1:0] DEPTH_4      = 2'd1;
    localparam logic [1:0] DEPTH_16     = 2'd2;
    localparam logic [1:0] DEPTH_DIRECT = 2'd3;

    localparam logic [1:0] MODE_TWO_BYTE = 2'd0;

    localparam int PAL_DEPTH = 8;
    localparam int PAL_AW    = 3;
    localparam int BIAS_W    = 5;

    typedef struct packed {
        logic [1:0] colour_depth;
        logic [1:0] cell_mode;
    } cfg_t;

endpackage

// ===== rtl/char_cell_pixel_decoder.sv =====
// Top level of the character cell pixel decoder.
// Cell register, palette memory read stage and output register.
// Depends on ccpd_pkg and ccpd_pixel_index.
//
// Each decode beat gives sixteen pixel beats, one per clock while the output
// is taken; the next cell is accepted as the sixteenth pixel of the current
// one issues its palette read, so cells stream with no gap. Palette and bias
// write beats are taken once every pixel of the cells before them has read
// the palette. The decode beat reaches its first pixel through the cell
// register, the palette memory read and the output register. Palette
// entries read as zero until written.
module char_cell_pixel_decoder import ccpd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_action,
    input  logic [7:0]            s_first_pixel_byte,
    input  logic [7:0]            s_second_pixel_byte,
    input  logic [7:0]            s_attribute_byte,
    input  logic [2:0]            s_palette_slot,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_colour_index,
    output logic                  m_last_pixel
);

    cfg_t              cfg_reg;
    logic [BIAS_W-1:0] bias_reg;

    logic              cell_vld_reg;
    logic [3:0]        cnt_reg;
    logic [7:0]        b0_reg;
    logic [7:0]        b1_reg;
    logic [7:0]        attr_reg;

    logic              p1_vld_reg;
    logic              p1_last_reg;
    logic              p1_use_pal_reg;
    logic [7:0]        p1_alt_reg;

    logic [7:0]        pal_mem [PAL_DEPTH];
    logic [PAL_DEPTH-1:0] pal_vld_reg;
    logic [7:0]        pal_rdata_reg;
    logic              pal_rvld_reg;

    logic              out_vld_reg;
    logic              out_last_reg;
    logic [7:0]        out_colour_reg;

    logic              adv;
    logic              cell_free;
    logic              s_fire;
    logic              take_cell;
    logic              take_pal;
    logic              take_bias;
    logic [7:0]        direct_colour;
    logic [3:0]        pal_index;
    logic              rd_en;
    logic [7:0]        p1_alt_next;
    logic              p1_use_pal_next;
    logic [7:0]        out_colour_next;

    ccpd_pixel_index u_index (
        .cfg           (cfg_reg),
        .pix_num       (cnt_reg),
        .first_byte    (b0_reg),
        .second_byte   (b1_reg),
        .attr_byte     (attr_reg),
        .direct_colour (direct_colour),
        .pal_index     (pal_index)
    );

    assign adv       = !out_vld_reg || m_ready;
    assign rd_en     = adv && cell_vld_reg;
    assign cell_free = !cell_vld_reg || (rd_en && (cnt_reg == 4'd15));
    assign s_ready   = (s_action == ACT_DECODE) ? cell_free : !cell_vld_reg;
    assign s_fire    = s_valid && s_ready;
    assign take_cell = s_fire && (s_action == ACT_DECODE);
    assign take_pal  = s_fire && (s_action == ACT_PAL_WRITE);
    assign take_bias = s_fire && (s_action == ACT_BIAS);

    always_comb begin
        p1_use_pal_next = (cfg_reg.colour_depth != DEPTH_DIRECT) && !pal_index[3];
        p1_alt_next     = (cfg_reg.colour_depth == DEPTH_DIRECT) ? direct_colour
                                                                 : {bias_reg, pal_index[2:0]};
        out_colour_next = p1_use_pal_reg ? (pal_rvld_reg ? pal_rdata_reg : 8'd0)
                                         : p1_alt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_COLOUR_DEPTH: cfg_reg.colour_depth <= cfg_wdata;
                CFG_CELL_MODE:    cfg_reg.cell_mode    <= cfg_wdata;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg    <= '0;
            pal_vld_reg <= '0;
        end else begin
            if (take_bias) begin
                bias_reg <= s_first_pixel_byte[BIAS_W-1:0];
            end
            if (take_pal) begin
                pal_vld_reg[s_palette_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_pal) begin
            pal_mem[s_palette_slot] <= s_first_pixel_byte;
        end
        if (rd_en) begin
            pal_rdata_reg <= pal_mem[pal_index[PAL_AW-1:0]];
            pal_rvld_reg  <= pal_vld_reg[pal_index[PAL_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_vld_reg <= 1'b0;
            cnt_reg      <= 4'd0;
        end else if (take_cell) begin
            cell_vld_reg <= 1'b1;
            cnt_reg      <= 4'd0;
        end else if (rd_en) begin
            cell_vld_reg <= (cnt_reg != 4'd15);
            cnt_reg      <= cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_cell) begin
            b0_reg   <= s_first_pixel_byte;
            b1_reg   <= s_second_pixel_byte;
            attr_reg <= s_attribute_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            p1_vld_reg  <= cell_vld_reg;
            out_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_last_reg    <= (cnt_reg == 4'd15);
            p1_use_pal_reg <= p1_use_pal_next;
            p1_alt_reg     <= p1_alt_next;
            out_last_reg   <= p1_last_reg;
            out_colour_reg <= out_colour_next;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_colour_index = out_colour_reg;
    assign m_last_pixel   = out_last_reg;

    a_write_after_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (take_pal || take_bias) |-> !cell_vld_reg && !rd_en)
        else $error("palette or bias write while cell reads pending");

    a_cell_start: assert property (@(posedge aclk) disable iff (!aresetn)
        take_cell |=> cell_vld_reg && (cnt_reg == 4'd0))
        else $error("cell not started at pixel zero");

    a_last_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && (cnt_reg == 4'd15)) |=> p1_vld_reg && p1_last_reg)
        else $error("end mark lost in read stage");

endmodule

// ===== rtl/ccpd_pixel_index.sv =====
// Pixel index extraction for one pixel of a character cell.
// Selects the pixel byte, de-interleaves the index and applies attribute mode.
// Depends on ccpd_pkg.
module ccpd_pixel_index import ccpd_pkg::*; (
    input  cfg_t       cfg,
    input  logic [3:0] pix_num,
    input  logic [7:0] first_byte,
    input  logic [7:0] second_byte,
    input  logic [7:0] attr_byte,
    output logic [7:0] direct_colour,
    output logic [3:0] pal_index
);

    logic       two;
    logic [7:0] c;
    logic [7:0] cs;
    logic [3:0] idx;

    always_comb begin
        two = (cfg.cell_mode == MODE_TWO_BYTE);
        c   = (two && pix_num[3]) ? second_byte : first_byte;
        cs  = c;
        idx = 4'd0;
        case (cfg.colour_depth)
            DEPTH_2: begin
                cs  = c << (two ? pix_num[2:0] : pix_num[3:1]);
                idx = {3'd0, cs[7]};
            end
            DEPTH_4: begin
                cs  = c >> (2'd3 - (two ? pix_num[2:1] : pix_num[3:2]));
                idx = {2'd0, cs[0], cs[4]};
            end
            default: begin
                cs  = c >> (1'b1 - (two ? pix_num[2] : pix_num[3]));
                idx = {cs[0], cs[4], cs[2], cs[6]};
            end
        endcase
        if (cfg.cell_mode[1]) begin
            idx = idx[0] ? attr_byte[3:0] : attr_byte[7:4];
        end
        direct_colour = c;
        pal_index     = idx;
    end

endmodule

// ===== tb/char_cell_pixel_decoder_test.sv =====
// Self-checking testbench for char_cell_pixel_decoder.
// Sends cells and palette/bias writes under random backpressure and checks every pixel beat
// against an in-bench colour predictor. Depends on ccpd_pkg and the RTL top level only.
module char_cell_pixel_decoder_test import ccpd_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_DOUBLED  = 2'd1;
    localparam logic [1:0] MODE_ATTR     = 2'd2;
    localparam logic [1:0] MODE_ATTR_ALT = 2'd3;

    localparam int PIXELS_PER_CELL = 16;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 16;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int RANDOM_PHASES   = 7;
    localparam int BEATS_PER_PHASE = 20;

    typedef struct packed {
        logic [7:0] colour;
        logic       last;
    } pixel_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_action;
    logic [7:0]            s_first_pixel_byte;
    logic [7:0]            s_second_pixel_byte;
    logic [7:0]            s_attribute_byte;
    logic [2:0]            s_palette_slot;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_colour_index;
    logic                  m_last_pixel;

    logic [7:0]          palette_mem [PAL_DEPTH];
    logic [BIAS_W-1:0]   bias_reg;
    logic [1:0]          depth_reg;
    logic [1:0]          mode_reg;

    pixel_t pending_pixels [$];
    pixel_t next_pixel;
    int     error_count;
    int     pixels_checked;
    int     cycle_count;
    int     burst_left;

    char_cell_pixel_decoder dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_action            (s_action),
        .s_first_pixel_byte  (s_first_pixel_byte),
        .s_second_pixel_byte (s_second_pixel_byte),
        .s_attribute_byte    (s_attribute_byte),
        .s_palette_slot      (s_palette_slot),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_colour_index      (m_colour_index),
        .m_last_pixel        (m_last_pixel)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(string msg);
        error_count++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic logic [7:0] cell_pixel_colour(logic [3:0] pix, logic [7:0] b0,
                                                     logic [7:0] b1, logic [7:0] attr);
        logic       two_byte;
        logic [7:0] src;
        logic [7:0] shifted;
        logic [3:0] nib;
        logic [2:0] bitpos;
        logic [1:0] pair;
        two_byte = (mode_reg == MODE_TWO_BYTE);
        src = (two_byte && pix[3]) ? b1 : b0;
        if (depth_reg == DEPTH_DIRECT) begin
            return src;
        end
        case (depth_reg)
            DEPTH_2: begin
                bitpos = two_byte ? pix[2:0] : pix[3:1];
                nib = {3'b000, src[3'd7 - bitpos]};
            end
            DEPTH_4: begin
                pair = two_byte ? pix[2:1] : pix[3:2];
                shifted = src >> (2'd3 - pair);
                nib = {2'b00, shifted[0], shifted[4]};
            end
            default: begin
                shifted = (two_byte ? pix[2] : pix[3]) ? src : (src >> 1);
                nib = {shifted[0], shifted[4], shifted[2], shifted[6]};
            end
        endcase
        if (mode_reg[1]) begin
            nib = nib[0] ? attr[3:0] : attr[7:4];
        end
        return nib[3] ? {bias_reg, nib[2:0]} : palette_mem[nib[2:0]];
    endfunction

    task automatic absorb_beat(action_t act, logic [7:0] b0, logic [7:0] b1,
                               logic [7:0] attr, logic [2:0] slot);
        pixel_t px;
        case (act)
            ACT_DECODE: begin
                for (int p = 0; p < PIXELS_PER_CELL; p++) begin
                    px.colour = cell_pixel_colour(p[3:0], b0, b1, attr);
                    px.last   = (p == PIXELS_PER_CELL - 1);
                    pending_pixels = {pending_pixels, px};
                end
            end
            ACT_PAL_WRITE: palette_mem[slot] = b0;
            ACT_BIAS:      bias_reg = b0[BIAS_W-1:0];
            default: ;
        endcase
    endtask

    // Call at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(action_t act, logic [7:0] b0, logic [7:0] b1,
                             logic [7:0] attr, logic [2:0] slot);
        if (burst_left == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        s_action            = act;
        s_first_pixel_byte  = b0;
        s_second_pixel_byte = b1;
        s_attribute_byte    = attr;
        s_palette_slot      = slot;
        s_valid             = 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        absorb_beat(act, b0, b1, attr, slot);
        burst_left--;
        @(negedge aclk);
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_beat(logic cells_only);
        int         pick;
        action_t    act;
        logic [2:0] slot;
        pick = cells_only ? 0 : $urandom_range(0, 19);
        if (pick < 14) begin
            act = ACT_DECODE;
        end else if (pick < 17) begin
            act = ACT_PAL_WRITE;
        end else if (pick < 19) begin
            act = ACT_BIAS;
        end else begin
            act = ACT_NONE;
        end
        slot = 3'($urandom_range(0, 7));
        send_beat(act, rand_byte(), rand_byte(), rand_byte(), slot);
    endtask

    task automatic drain_pixels();
        s_valid    = 1'b0;
        burst_left = 0;
        while (pending_pixels.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == CFG_COLOUR_DEPTH) begin
            depth_reg = value;
        end else begin
            mode_reg = value;
        end
    endtask

    task automatic set_mode(logic [1:0] depth, logic [1:0] mode);
        drain_pixels();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_reg(CFG_COLOUR_DEPTH, depth);
        write_reg(CFG_CELL_MODE, mode);
    endtask

    task automatic test_reset_state();
        send_beat(ACT_DECODE, 8'h00, 8'hFF, 8'h00, 3'd0);
        send_beat(ACT_DECODE, 8'hFF, 8'h00, 8'hFF, 3'd7);
    endtask

    task automatic test_directed_cells();
        logic [7:0] pal_values [PAL_DEPTH];
        pal_values = '{8'hFF, 8'h01, 8'h80, 8'h7F, 8'hA5, 8'h5A, 8'h3C, 8'h00};
        for (int k = 0; k < PAL_DEPTH; k++) begin
            send_beat(ACT_PAL_WRITE, pal_values[k], 8'h00, 8'h00, 3'(k));
        end
        // upper three bits of the bias value must be dropped
        send_beat(ACT_BIAS, 8'hFF, 8'h00, 8'h00, 3'd0);
        send_beat(ACT_NONE, 8'h00, 8'hFF, 8'hFF, 3'd0);
        for (int d = 0; d < 4; d++) begin
            for (int m = 0; m < 3; m++) begin
                set_mode(2'(d), 2'(m));
                send_beat(ACT_DECODE, 8'h96, 8'h3C, 8'hC3, 3'd0);
            end
        end
        set_mode(DEPTH_16, MODE_ATTR_ALT);
        send_beat(ACT_DECODE, 8'h69, 8'hC3, 8'h8E, 3'd5);
    endtask

    task automatic test_random_phases();
        logic [1:0] depth;
        logic [1:0] mode;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       begin depth = DEPTH_DIRECT; mode = MODE_ATTR_ALT; end
                1:       begin depth = DEPTH_2;      mode = MODE_TWO_BYTE; end
                2:       begin depth = DEPTH_16;     mode = MODE_ATTR;     end
                3:       begin depth = DEPTH_4;      mode = MODE_DOUBLED;  end
                default: begin
                    depth = 2'($urandom_range(0, 3));
                    mode  = 2'($urandom_range(0, 3));
                end
            endcase
            set_mode(depth, mode);
            repeat (BEATS_PER_PHASE) send_random_beat(1'b0);
        end
    endtask

    task automatic test_pause_until_drained();
        set_mode(DEPTH_16, MODE_TWO_BYTE);
        repeat (5) send_random_beat(1'b1);
        drain_pixels();
        repeat (5) send_random_beat(1'b1);
    endtask

    initial begin
        int run_left;
        run_left = 0;
        m_ready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (run_left > 0) begin
                run_left--;
            end else begin
                case ($urandom_range(0, 9))
                    0:       begin m_ready = 1'b1; run_left = $urandom_range(60, 150); end
                    1, 2, 3: begin m_ready = 1'b0; run_left = $urandom_range(1, 8);    end
                    default: begin m_ready = 1'b1; run_left = $urandom_range(1, 12);   end
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel beat colour %02h last %b",
                                          m_colour_index, m_last_pixel));
            end else begin
                next_pixel = pending_pixels.pop_front();
                if (m_colour_index !== next_pixel.colour) begin
                    report_mismatch($sformatf("pixel %0d colour %02h, want %02h",
                                              pixels_checked, m_colour_index,
                                              next_pixel.colour));
                end
                if (m_last_pixel !== next_pixel.last) begin
                    report_mismatch($sformatf("pixel %0d last %b, want %b",
                                              pixels_checked, m_last_pixel,
                                              next_pixel.last));
                end
            end
            pixels_checked++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycle_count, pending_pixels.size());
            $display("char_cell_pixel_decoder verification failed");
            $finish;
        end
    end

    initial begin
        aresetn             = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_index           = '0;
        cfg_wdata           = '0;
        s_valid             = 1'b0;
        s_action            = '0;
        s_first_pixel_byte  = '0;
        s_second_pixel_byte = '0;
        s_attribute_byte    = '0;
        s_palette_slot      = '0;
        for (int k = 0; k < PAL_DEPTH; k++) begin
            palette_mem[k] = '0;
        end
        bias_reg       = '0;
        depth_reg      = DEPTH_2;
        mode_reg       = MODE_TWO_BYTE;
        error_count    = 0;
        pixels_checked = 0;
        cycle_count    = 0;
        burst_left     = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_state();
        test_directed_cells();
        test_random_phases();
        test_pause_until_drained();

        drain_pixels();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("char_cell_pixel_decoder verification clean");
        end else begin
            $display("char_cell_pixel_decoder verification failed");
        end
        $finish;
    end

endmodule
